// ===== rtl/fraction_reduce_macros.svh =====
// ----------------------------------------------------------------------------
// fraction_reduce_macros.svh
// Assertion macros shared by the fraction reduction block.
// ----------------------------------------------------------------------------
`ifndef FRACTION_REDUCE_MACROS_SVH
`define FRACTION_REDUCE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define FR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fraction_reduce: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define FR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fraction_reduce: next-cycle check failed");

`endif

// ===== rtl/fr_pkg.sv =====
// ----------------------------------------------------------------------------
// fr_pkg
// Shared widths, datapath op codes and control/status types.
// ----------------------------------------------------------------------------
package fr_pkg;

  localparam int DATA_W  = 64;
  localparam int SHIFT_W = $clog2(DATA_W);
  localparam int CNT_W   = $clog2(DATA_W);

  localparam logic [DATA_W-1:0] MINUS_ONE = '1;
  localparam logic [DATA_W-1:0] ONE       = {{(DATA_W-1){1'b0}}, 1'b1};

  typedef logic [DATA_W-1:0] word_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_HALVE_BOTH,
    OP_HALVE_A,
    OP_GCD_STEP,
    OP_START_DIV,
    OP_DIV_STEP,
    OP_DIV_LAST_NUM,
    OP_DIV_LAST_DEN,
    OP_SIGN_FIX,
    OP_BOTH_NEG,
    OP_MINUS_ONE,
    OP_OUT_LOAD
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic a_zero;
    logic b_zero;
    logic a_even;
    logic both_even;
    logic cnt_last;
    logic g_zero;
  } status_t;

  function automatic word_t neg(input word_t v);
    neg = '0 - v;
  endfunction

  function automatic word_t mag(input word_t v);
    mag = v[DATA_W-1] ? neg(v) : v;
  endfunction

endpackage

// ===== rtl/fr_dp.sv =====
// ----------------------------------------------------------------------------
// fr_dp
// Datapath: binary gcd registers, shared restoring divider, sign fix-up and
// output register.
// ----------------------------------------------------------------------------
module fr_dp (
  input  logic                        clk,
  input  fr_pkg::cmd_t                cmd,
  input  logic signed [fr_pkg::DATA_W-1:0] in_num,
  input  logic signed [fr_pkg::DATA_W-1:0] in_den,
  output fr_pkg::status_t             status,
  output logic signed [fr_pkg::DATA_W-1:0] out_num,
  output logic signed [fr_pkg::DATA_W-1:0] out_den
);
  import fr_pkg::*;

  word_t             num_r, num_nxt;
  word_t             den_r, den_nxt;
  logic              sn_r, sn_nxt;
  logic              sd_r, sd_nxt;
  word_t             a_r, a_nxt;
  word_t             b_r, b_nxt;
  logic [SHIFT_W-1:0] k_r, k_nxt;
  word_t             g_r, g_nxt;
  word_t             rem_r, rem_nxt;
  word_t             quo_r, quo_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  word_t             onum_r, onum_nxt;
  word_t             oden_r, oden_nxt;

  logic [DATA_W:0]   b_minus_a;
  word_t             a_minus_b;
  word_t             g_cand;
  logic [DATA_W:0]   trial;
  logic              qbit;
  word_t             quo_done;

  assign b_minus_a = {1'b0, b_r} - {1'b0, a_r};
  assign a_minus_b = a_r - b_r;
  // gcd is the other value when one is zero, else the odd core shifted back
  assign g_cand    = (a_r == '0) ? b_r : (a_r << k_r);

  assign trial     = {rem_r, quo_r[DATA_W-1]} - {1'b0, g_r};
  assign qbit      = !trial[DATA_W];
  assign quo_done  = {quo_r[DATA_W-2:0], qbit};

  always_comb begin
    num_nxt  = num_r;
    den_nxt  = den_r;
    sn_nxt   = sn_r;
    sd_nxt   = sd_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    k_nxt    = k_r;
    g_nxt    = g_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    onum_nxt = onum_r;
    oden_nxt = oden_r;
    unique case (cmd.op)
      OP_NONE: begin
      end
      OP_LOAD: begin
        num_nxt = in_num;
        den_nxt = in_den;
        sn_nxt  = in_num[DATA_W-1];
        sd_nxt  = in_den[DATA_W-1];
        a_nxt   = mag(in_num);
        b_nxt   = mag(in_den);
        k_nxt   = '0;
      end
      OP_HALVE_BOTH: begin
        a_nxt = a_r >> 1;
        b_nxt = b_r >> 1;
        k_nxt = k_r + 1'b1;
      end
      OP_HALVE_A: begin
        a_nxt = a_r >> 1;
      end
      OP_GCD_STEP: begin
        if (!b_r[0]) begin
          b_nxt = b_r >> 1;
        end else if (b_minus_a[DATA_W]) begin
          // a > b: swap, then subtract
          a_nxt = b_r;
          b_nxt = a_minus_b;
        end else begin
          b_nxt = b_minus_a[DATA_W-1:0];
        end
      end
      OP_START_DIV: begin
        g_nxt   = g_cand;
        rem_nxt = '0;
        quo_nxt = mag(num_r);
        cnt_nxt = '0;
      end
      OP_DIV_STEP: begin
        rem_nxt = qbit ? trial[DATA_W-1:0] : {rem_r[DATA_W-2:0], quo_r[DATA_W-1]};
        quo_nxt = quo_done;
        cnt_nxt = cnt_r + 1'b1;
      end
      OP_DIV_LAST_NUM: begin
        num_nxt = quo_done;
        rem_nxt = '0;
        quo_nxt = mag(den_r);
        cnt_nxt = '0;
      end
      OP_DIV_LAST_DEN: begin
        den_nxt = quo_done;
      end
      OP_SIGN_FIX: begin
        num_nxt = sn_r ? neg(num_r) : num_r;
        den_nxt = sd_r ? neg(den_r) : den_r;
      end
      OP_BOTH_NEG: begin
        if (num_r[DATA_W-1] && den_r[DATA_W-1]) begin
          num_nxt = neg(num_r);
          den_nxt = neg(den_r);
        end
      end
      OP_MINUS_ONE: begin
        if (den_r == MINUS_ONE) begin
          den_nxt = ONE;
          num_nxt = neg(num_r);
        end
      end
      OP_OUT_LOAD: begin
        onum_nxt = num_r;
        oden_nxt = den_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    num_r  <= num_nxt;
    den_r  <= den_nxt;
    sn_r   <= sn_nxt;
    sd_r   <= sd_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    k_r    <= k_nxt;
    g_r    <= g_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    cnt_r  <= cnt_nxt;
    onum_r <= onum_nxt;
    oden_r <= oden_nxt;
  end

  assign status.a_zero    = (a_r == '0);
  assign status.b_zero    = (b_r == '0);
  assign status.a_even    = !a_r[0];
  assign status.both_even = !(a_r[0] | b_r[0]);
  assign status.cnt_last  = (cnt_r == '1);
  assign status.g_zero    = (g_r == '0);

  assign out_num = onum_r;
  assign out_den = oden_r;

endmodule

// ===== rtl/fr_ctrl.sv =====
// ----------------------------------------------------------------------------
// fr_ctrl
// Controller: sequences gcd, two divisions, sign fix-up and the output
// handshake.
// ----------------------------------------------------------------------------
module fr_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  fr_pkg::status_t status,
  output fr_pkg::cmd_t    cmd,
  output logic            dividing
);
  import fr_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_CHK   = 11'b000_0000_0010,
    S_SHIFT = 11'b000_0000_0100,
    S_AODD  = 11'b000_0000_1000,
    S_LOOP  = 11'b000_0001_0000,
    S_DIVN  = 11'b000_0010_0000,
    S_DIVD  = 11'b000_0100_0000,
    S_SIGN  = 11'b000_1000_0000,
    S_NEG   = 11'b001_0000_0000,
    S_MONE  = 11'b010_0000_0000,
    S_DONE  = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   ovalid_r, ovalid_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd.op     = OP_NONE;
    ovalid_nxt = ovalid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (status.a_zero && status.b_zero) begin
          // both zero: pass the pair through
          state_nxt = S_DONE;
        end else if (status.a_zero || status.b_zero) begin
          cmd.op    = OP_START_DIV;
          state_nxt = S_DIVN;
        end else begin
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (status.both_even) begin
          cmd.op = OP_HALVE_BOTH;
        end else begin
          state_nxt = S_AODD;
        end
      end
      S_AODD: begin
        if (status.a_even) begin
          cmd.op = OP_HALVE_A;
        end else begin
          state_nxt = S_LOOP;
        end
      end
      S_LOOP: begin
        if (status.b_zero) begin
          cmd.op    = OP_START_DIV;
          state_nxt = S_DIVN;
        end else begin
          cmd.op = OP_GCD_STEP;
        end
      end
      S_DIVN: begin
        if (status.cnt_last) begin
          cmd.op    = OP_DIV_LAST_NUM;
          state_nxt = S_DIVD;
        end else begin
          cmd.op = OP_DIV_STEP;
        end
      end
      S_DIVD: begin
        if (status.cnt_last) begin
          cmd.op    = OP_DIV_LAST_DEN;
          state_nxt = S_SIGN;
        end else begin
          cmd.op = OP_DIV_STEP;
        end
      end
      S_SIGN: begin
        cmd.op    = OP_SIGN_FIX;
        state_nxt = S_NEG;
      end
      S_NEG: begin
        cmd.op    = OP_BOTH_NEG;
        state_nxt = S_MONE;
      end
      S_MONE: begin
        cmd.op    = OP_MINUS_ONE;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // hold until the output register is free
        if (!ovalid_r || out_ready) begin
          cmd.op     = OP_OUT_LOAD;
          ovalid_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = ovalid_r;
  assign dividing  = (state_r == S_DIVN) || (state_r == S_DIVD);

endmodule

// ===== rtl/fraction_reduce.sv =====
// ----------------------------------------------------------------------------
// fraction_reduce
// Reduces a signed 64-bit fraction to lowest terms via binary gcd.
// ----------------------------------------------------------------------------
// One fraction is worked on at a time. After a transfer the block runs a
// binary gcd (one halving or one compare-and-subtract per cycle, shared
// factors of two halved out first), then divides the numerator and the
// denominator by the gcd in turn on one restoring divider, then does the
// sign fix-up (signs restored, a both-negative pair negated, a -1
// denominator made 1) and loads the output register. Both-zero input
// passes through without the gcd or the divider. A finished result waits
// in the output register while the next fraction is taken in and reduced.
module fraction_reduce (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [fr_pkg::DATA_W-1:0] in_num_in,
  input  logic signed [fr_pkg::DATA_W-1:0] in_den_in,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [fr_pkg::DATA_W-1:0] out_num_out,
  output logic signed [fr_pkg::DATA_W-1:0] out_den_out
);
  import fr_pkg::*;

  `include "fraction_reduce_macros.svh"

  cmd_t    cmd;
  status_t status;
  logic    dividing;

  fr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd),
    .dividing  (dividing)
  );

  fr_dp u_dp (
    .clk     (clk),
    .cmd     (cmd),
    .in_num  (in_num_in),
    .in_den  (in_den_in),
    .status  (status),
    .out_num (out_num_out),
    .out_den (out_den_out)
  );

  `FR_ASSERT_NEXT(a_busy_after_transfer, in_valid && in_ready, !in_ready)
  `FR_ASSERT_NOW(a_divisor_nonzero, dividing, !status.g_zero)
  `FR_ASSERT_NOW(a_result_from_busy, $rose(out_valid), !$past(in_ready))

endmodule
